/* design/u8dw_pkg.sv */
package u8dw_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [20:0] code_point_t;
    typedef logic [1:0]  tail_len_t;

    localparam code_point_t HANGUL_JAMO_LO  = 21'h01100;
    localparam code_point_t HANGUL_JAMO_HI  = 21'h0115F;
    localparam code_point_t CJK_LO          = 21'h02E80;
    localparam code_point_t CJK_HI          = 21'h0A4CF;
    localparam code_point_t HANGUL_SYL_LO   = 21'h0AC00;
    localparam code_point_t HANGUL_SYL_HI   = 21'h0D7A3;
    localparam code_point_t CJK_COMPAT_LO   = 21'h0F900;
    localparam code_point_t CJK_COMPAT_HI   = 21'h0FAFF;
    localparam code_point_t VERT_FORMS_LO   = 21'h0FE30;
    localparam code_point_t VERT_FORMS_HI   = 21'h0FE6F;
    localparam code_point_t FULLWIDTH_LO    = 21'h0FF00;
    localparam code_point_t FULLWIDTH_HI    = 21'h0FF60;
    localparam code_point_t FW_SIGNS_LO     = 21'h0FFE0;
    localparam code_point_t FW_SIGNS_HI     = 21'h0FFE6;
    localparam code_point_t SUPP_IDEO_LO    = 21'h20000;
    localparam code_point_t SUPP_IDEO_HI    = 21'h3FFFD;

    // tail bytes a lead byte asks for; 0 for ASCII and stray bytes
    function automatic tail_len_t tail_len(input byte_t c);
        tail_len_t len;
        if (c[7:5] == 3'b110) begin
            len = 2'd1;
        end else if (c[7:4] == 4'b1110) begin
            len = 2'd2;
        end else if (c[7:3] == 5'b11110) begin
            len = 2'd3;
        end else begin
            len = 2'd0;
        end
        return len;
    endfunction

    function automatic logic is_wide(input code_point_t cp);
        return (cp >= HANGUL_JAMO_LO && cp <= HANGUL_JAMO_HI) ||
               (cp >= CJK_LO         && cp <= CJK_HI)         ||
               (cp >= HANGUL_SYL_LO  && cp <= HANGUL_SYL_HI)  ||
               (cp >= CJK_COMPAT_LO  && cp <= CJK_COMPAT_HI)  ||
               (cp >= VERT_FORMS_LO  && cp <= VERT_FORMS_HI)  ||
               (cp >= FULLWIDTH_LO   && cp <= FULLWIDTH_HI)   ||
               (cp >= FW_SIGNS_LO    && cp <= FW_SIGNS_HI)    ||
               (cp >= SUPP_IDEO_LO   && cp <= SUPP_IDEO_HI);
    endfunction

endpackage

/* design/utf8_display_width.sv */
// channel | valid   | ready   | payload
// --------+---------+---------+--------------------------------------------
// input   | s_valid | s_ready | s_text_byte, s_end_of_string
// result  | m_valid | m_ready | m_display_width (one per string)
//
// One byte per cycle sustained while no final byte waits on a stalled
// result. A byte sits in the input register, where the decode, range compare
// and saturating add run against the pending bytes; the final byte of a
// string then loads the result register. Synchronous active-low reset clears
// the valid flags and decode state, not the data registers. A stalled result
// holds only a final byte in the input register; other bytes keep flowing.
module utf8_display_width #(
    parameter int COUNT_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  u8dw_pkg::byte_t   s_text_byte,
    input  logic              s_end_of_string,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_display_width
);
    import u8dw_pkg::*;

    logic                  in_valid_reg;
    byte_t                 in_byte_reg;
    logic                  in_eos_reg;

    byte_t                 pend_reg [0:2];
    byte_t                 pend_next [0:2];
    logic [1:0]            pend_count_reg, pend_count_next;
    logic [1:0]            tail_needed_reg, tail_needed_next;
    logic [COUNT_BITS-1:0] run_reg, run_next;

    logic                  out_valid_reg;
    logic [31:0]           out_width_reg;

    logic                  advance;
    tail_len_t             lead_len;
    tail_len_t             byte_len;
    code_point_t           cp;
    logic [1:0]            cp_cols;
    logic [1:0]            add_cols;
    logic [COUNT_BITS:0]   sum;
    logic [COUNT_BITS-1:0] sat_sum;
    logic                  continuing;

    assign advance = in_valid_reg && (!in_eos_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_display_width = out_width_reg;

    assign lead_len   = tail_len(pend_reg[0]);
    assign byte_len   = tail_len(in_byte_reg);
    assign continuing = (tail_needed_reg != 2'd0) && (pend_count_reg != 2'd0);

    // decode treats the current byte as the last tail byte of a completed sequence
    always_comb begin
        case (lead_len)
            2'd1:    cp = {10'd0, pend_reg[0][4:0], in_byte_reg[5:0]};
            2'd2:    cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte_reg[5:0]};
            2'd3:    cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                           in_byte_reg[5:0]};
            default: cp = '0;
        endcase
        cp_cols = is_wide(cp) ? 2'd2 : 2'd1;
    end

    always_comb begin
        add_cols = 2'd0;
        if (in_eos_reg) begin
            if (pend_count_reg == 2'd0) begin
                add_cols = 2'd1;
            end else if (lead_len != 2'd0 && lead_len <= pend_count_reg) begin
                add_cols = cp_cols;
            end else if (pend_count_reg == 2'd1) begin
                add_cols = 2'd2;
            end else if (tail_len(pend_reg[1]) == 2'd1) begin
                // lead alone, then a two-byte form from the rest
                add_cols = 2'd2;
            end else begin
                add_cols = 2'd3;
            end
        end else if (continuing) begin
            if (tail_needed_reg == 2'd1) begin
                add_cols = cp_cols;
            end
        end else if (byte_len == 2'd0) begin
            add_cols = 2'd1;
        end
    end

    assign sum     = {1'b0, run_reg} + (COUNT_BITS+1)'(add_cols);
    assign sat_sum = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

    always_comb begin
        pend_next[0]     = pend_reg[0];
        pend_next[1]     = pend_reg[1];
        pend_next[2]     = pend_reg[2];
        pend_count_next  = pend_count_reg;
        tail_needed_next = tail_needed_reg;
        run_next         = sat_sum;
        if (in_eos_reg) begin
            pend_next[0]     = '0;
            pend_next[1]     = '0;
            pend_next[2]     = '0;
            pend_count_next  = 2'd0;
            tail_needed_next = 2'd0;
            run_next         = '0;
        end else if (continuing) begin
            if (pend_count_reg != 2'd3) begin
                pend_next[pend_count_reg] = in_byte_reg;
                pend_count_next = pend_count_reg + 2'd1;
            end
            tail_needed_next = tail_needed_reg - 2'd1;
            if (tail_needed_reg == 2'd1) begin
                pend_count_next = 2'd0;
            end
        end else begin
            tail_needed_next = byte_len;
            if (byte_len == 2'd0) begin
                pend_count_next = 2'd0;
            end else begin
                pend_next[0]    = in_byte_reg;
                pend_count_next = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pend_reg[0]     <= '0;
            pend_reg[1]     <= '0;
            pend_reg[2]     <= '0;
            pend_count_reg  <= 2'd0;
            tail_needed_reg <= 2'd0;
            run_reg         <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                pend_reg[0]     <= pend_next[0];
                pend_reg[1]     <= pend_next[1];
                pend_reg[2]     <= pend_next[2];
                pend_count_reg  <= pend_count_next;
                tail_needed_reg <= tail_needed_next;
                run_reg         <= run_next;
            end

            if (advance && in_eos_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_eos_reg  <= s_end_of_string;
        end
        if (advance && in_eos_reg) begin
            out_width_reg <= 32'(sat_sum);
        end
    end

endmodule

/* design/u8dw_checker.sv */
module u8dw_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input u8dw_pkg::byte_t   s_text_byte,
    input logic              s_end_of_string,
    input logic              m_valid,
    input logic              m_ready,
    input logic [31:0]       m_display_width
);

    // a free result side never blocks input
    a_ready_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low while result register empty");

    // final byte: result valid once it has passed the input and result registers
    a_eos_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_string) |=> ##1 m_valid)
        else $error("no result after final byte");

    a_input_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && !s_ready) |=>
            (s_valid && $stable(s_text_byte) && $stable(s_end_of_string)))
        else $error("waiting request changed");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_display_width)))
        else $error("stalled result changed");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind utf8_display_width u8dw_checker u_u8dw_checker (.*);
